// ===== src/hbd_pkg.sv =====
package hbd_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SIZE  = 3'd1,
		PH_EXT   = 3'd2,
		PH_DATA  = 3'd3,
		PH_TRAIL = 3'd4,
		PH_FIXED = 3'd5,
		PH_DONE  = 3'd6,
		PH_ERROR = 3'd7
	} hbd_phase_t;

	typedef struct packed {
		hbd_phase_t  phase;
		logic [30:0] size_acc;
		logic [30:0] bytes_rem;
		logic        digit_seen;
		logic        cr_seen;
	} hbd_state_t;

	// body modes, anything else runs until close
	localparam logic [1:0] MODE_CHUNKED = 2'd0;
	localparam logic [1:0] MODE_FIXED   = 2'd1;

	// status codes
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// input commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOS  = 1'b1;

	// configuration register indexes
	localparam logic CFG_BODY_MODE      = 1'b0;
	localparam logic CFG_CONTENT_LENGTH = 1'b1;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

endpackage

// ===== src/http_body_dechunker.sv =====
// http body dechunker
// input channel: one transfer per item, cmd selects a stream byte (data_byte)
//   or the end-of-stream mark
// output channel: one transfer per input item carrying payload_byte,
//   payload_valid (byte is body data) and status (running, complete, error)
// config channel: cfg_index 0 writes body_mode (chunked, fixed length, until
//   close), cfg_index 1 writes content_length; cfg_ready is always high;
//   writes are to be made while the block is idle, which it does not enforce
// pipeline: an item sits in the input register, then its result goes into the
//   output register
// throughput: one item per cycle unless stalled; the whole per-byte parse is
//   one pass of combinational logic between the input and output registers
// stall: when out_ready is low the output register holds, the input register
//   fills and then in_ready drops; nothing is lost or repeated
// reset: arst_n clears both stage valids, the parser state to the start phase
//   and the config registers to chunked mode with zero length
// after complete or error every item reports the final status with no byte
module http_body_dechunker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);
	import hbd_pkg::*;

	// configuration
	logic [1:0]  body_mode_q;
	logic [30:0] content_length_q;

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] data_byte_s1;

	// output register
	logic       valid_s2;
	logic [7:0] payload_byte_s2;
	logic       payload_valid_s2;
	logic [1:0] status_s2;

	// parser state
	hbd_state_t st_q;
	hbd_state_t st_nxt;

	logic [7:0] res_byte;
	logic       res_valid;
	logic [1:0] res_status;

	logic advance;

	// item moves from input register to output register when the latter frees
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q      <= MODE_CHUNKED;
			content_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BODY_MODE:      body_mode_q      <= cfg_data[1:0];
				CFG_CONTENT_LENGTH: content_length_q <= cfg_data;
				default:            body_mode_q      <= body_mode_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1       <= cmd;
			data_byte_s1 <= data_byte;
		end
	end

	// per-byte parse against the current state
	hbd_step u_step (
		.cur            (st_q),
		.body_mode      (body_mode_q),
		.content_length (content_length_q),
		.cmd            (cmd_s1),
		.data_byte      (data_byte_s1),
		.nxt            (st_nxt),
		.payload_byte   (res_byte),
		.payload_valid  (res_valid),
		.status         (res_status)
	);

	// state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_START, size_acc: '0, bytes_rem: '0,
				digit_seen: 1'b0, cr_seen: 1'b0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			payload_byte_s2  <= res_byte;
			payload_valid_s2 <= res_valid;
			status_s2        <= res_status;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_byte  = payload_byte_s2;
	assign payload_valid = payload_valid_s2;
	assign status        = status_s2;

	// a delivered body byte never comes with an error
	a_no_byte_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && payload_valid_s2 |-> status_s2 != ST_ERR)
		else $error("body byte reported together with error status");

	// terminal phases are sticky
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DONE |=> st_q.phase == PH_DONE)
		else $error("left the done phase");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_ERROR |=> st_q.phase == PH_ERROR)
		else $error("left the error phase");

	// an error result shown on the port matches the committed state
	a_err_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ST_ERR |-> st_q.phase == PH_ERROR)
		else $error("error status without error phase");

endmodule

// ===== src/hbd_step.sv =====
module hbd_step (
	input  hbd_pkg::hbd_state_t cur,
	input  logic [1:0]          body_mode,
	input  logic [30:0]         content_length,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	output hbd_pkg::hbd_state_t nxt,
	output logic [7:0]          payload_byte,
	output logic                payload_valid,
	output logic [1:0]          status
);
	import hbd_pkg::*;

	// {is hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [4:0] r;
		begin
			r = '0;
			if (ch >= 8'h30 && ch <= 8'h39) begin
				r = {1'b1, ch[3:0]};
			end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
				r = {1'b1, 4'(ch[3:0] + 4'd9)};
			end
			return r;
		end
	endfunction

	function automatic logic is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF || ch == CH_CR;
	endfunction

	function automatic logic in_line(input hbd_phase_t p);
		return p == PH_SIZE || p == PH_EXT || p == PH_TRAIL;
	endfunction

	function automatic hbd_state_t line_char(input hbd_state_t s, input logic [7:0] ch);
		hbd_state_t r;
		logic [4:0] h;
		begin
			r = s;
			h = hex_decode(ch);
			if (s.phase == PH_SIZE) begin
				if (h[4]) begin
					if (s.size_acc[30:27] != 4'd0) begin
						r.phase = PH_ERROR;
					end else begin
						r.size_acc   = {s.size_acc[26:0], h[3:0]};
						r.digit_seen = 1'b1;
					end
				end else if (!s.digit_seen && is_blank(ch)) begin
					r.phase = PH_SIZE;
				end else if (ch == CH_SEMI && s.digit_seen) begin
					r.phase = PH_EXT;
				end else begin
					r.phase = PH_ERROR;
				end
			end else if (s.phase == PH_TRAIL) begin
				r.phase = PH_ERROR;
			end
			return r;
		end
	endfunction

	function automatic hbd_state_t line_end(input hbd_state_t s);
		hbd_state_t r;
		begin
			r = s;
			if (s.phase == PH_SIZE || s.phase == PH_EXT) begin
				if (!s.digit_seen) begin
					r.phase = PH_ERROR;
				end else if (s.size_acc == '0) begin
					r.phase = PH_DONE;
				end else begin
					r.bytes_rem = s.size_acc;
					r.phase     = PH_DATA;
				end
			end else if (s.phase == PH_TRAIL) begin
				r.phase      = PH_SIZE;
				r.size_acc   = '0;
				r.digit_seen = 1'b0;
			end
			return r;
		end
	endfunction

	function automatic hbd_state_t line_plain(input hbd_state_t s, input logic [7:0] ch);
		hbd_state_t r;
		begin
			r = s;
			if (ch == CH_CR) begin
				r.cr_seen = 1'b1;
			end else if (ch == CH_LF) begin
				r = line_end(s);
			end else begin
				r = line_char(s, ch);
			end
			return r;
		end
	endfunction

	hbd_state_t s;
	logic [30:0] rem_dec;

	always_comb begin
		s             = cur;
		payload_valid = 1'b0;
		payload_byte  = '0;
		rem_dec       = '0;

		// mode is sampled only at the start phase
		if (s.phase == PH_START) begin
			if (body_mode == MODE_CHUNKED) begin
				s.phase      = PH_SIZE;
				s.size_acc   = '0;
				s.digit_seen = 1'b0;
				s.cr_seen    = 1'b0;
			end else if (body_mode == MODE_FIXED) begin
				s.bytes_rem = content_length;
				s.phase     = (content_length == '0) ? PH_DONE : PH_FIXED;
			end else if (cmd == CMD_EOS) begin
				s.phase = PH_DONE;
			end else begin
				payload_valid = 1'b1;
				payload_byte  = data_byte;
			end
		end

		if (in_line(s.phase)) begin
			if (cmd == CMD_EOS) begin
				s.phase = PH_ERROR;
			end else if (s.cr_seen) begin
				s.cr_seen = 1'b0;
				if (data_byte == CH_LF) begin
					s = line_end(s);
				end else begin
					// lone cr counts as a line character
					s = line_char(s, CH_CR);
					if (in_line(s.phase)) begin
						s = line_plain(s, data_byte);
					end
				end
			end else begin
				s = line_plain(s, data_byte);
			end
		end else if (s.phase == PH_DATA || s.phase == PH_FIXED) begin
			if (cmd == CMD_EOS) begin
				s.phase = PH_ERROR;
			end else begin
				payload_valid = 1'b1;
				payload_byte  = data_byte;
				rem_dec       = s.bytes_rem - 31'd1;
				s.bytes_rem   = rem_dec;
				if (rem_dec == '0) begin
					s.phase = (s.phase == PH_DATA) ? PH_TRAIL : PH_DONE;
				end
			end
		end

		nxt = s;

		unique case (s.phase)
			PH_DONE:  status = ST_DONE;
			PH_ERROR: status = ST_ERR;
			default:  status = ST_RUN;
		endcase
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

	import hbd_pkg::*;

	// body modes the package leaves unnamed: both run until the stream closes
	localparam logic [1:0] MODE_CLOSE     = 2'd2;
	localparam logic [1:0] MODE_CLOSE_ALT = 2'd3;

	// cycles with no transfer on any channel before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// quiet cycles after the last result to catch stray output
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] pbyte;
		logic       pvalid;
		logic [1:0] stat;
	} body_out_t;

	// receiver ready patterns
	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_COMB
	} ready_style_t;

	// ways the chunked body is brought to its end
	typedef enum logic [3:0] {
		END_ZERO,
		END_NO_DIGIT,
		END_SIGN,
		END_HEX_PREFIX,
		END_BLANK_AFTER,
		END_BAD_CHAR,
		END_OVERFLOW,
		END_TRAILER,
		END_EOS_DATA,
		END_EOS_LINE
	} body_end_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = CMD_BYTE;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_BODY_MODE;
	logic [30:0] cfg_data = 31'd0;

	http_body_dechunker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// stream items waiting to be driven, and predicted results in order
	stream_item_t body_q[$];
	body_out_t    dechunked_q[$];

	int errors = 0;
	int planned = 0;
	int n_items = 0;
	int n_results = 0;
	int n_delivered = 0;
	int n_writes = 0;
	int drains = 0;
	logic [1:0] last_status = ST_RUN;
	bit in_fire = 1'b0;

	// ---------------------------------------------------------------------
	// predictor: a private copy of the parser state and both registers
	// ---------------------------------------------------------------------
	hbd_phase_t  p_phase = PH_START;
	logic [30:0] p_size = '0;
	logic [30:0] p_left = '0;
	logic        p_digit = 1'b0;
	logic        p_cr = 1'b0;
	logic [1:0]  p_mode = MODE_CHUNKED;
	logic [30:0] p_len = '0;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
	endfunction

	function automatic bit in_line();
		return p_phase == PH_SIZE || p_phase == PH_EXT || p_phase == PH_TRAIL;
	endfunction

	// one character of a size line or of the line after the data
	function automatic void size_line_char(input logic [7:0] c);
		int d;
		logic [35:0] grown;
		d = hex_nibble(c);
		if (p_phase == PH_SIZE) begin
			if (d >= 0) begin
				grown = 36'(p_size) * 36'd16 + 36'(d);
				if (grown > 36'h7FFF_FFFF) begin
					p_phase = PH_ERROR;
				end else begin
					p_size = grown[30:0];
					p_digit = 1'b1;
				end
			end else if (p_digit || !is_blank(c)) begin
				// blanks only pass before the first digit
				p_phase = (c == CH_SEMI && p_digit) ? PH_EXT : PH_ERROR;
			end
		end else if (p_phase == PH_TRAIL) begin
			p_phase = PH_ERROR;
		end
	endfunction

	function automatic void size_line_end();
		if (p_phase == PH_SIZE || p_phase == PH_EXT) begin
			if (!p_digit) begin
				p_phase = PH_ERROR;
			end else if (p_size == 0) begin
				p_phase = PH_DONE;
			end else begin
				p_left = p_size;
				p_phase = PH_DATA;
			end
		end else if (p_phase == PH_TRAIL) begin
			p_phase = PH_SIZE;
			p_size = '0;
			p_digit = 1'b0;
		end
	endfunction

	// cr is held back one byte: with lf it ends the line, else it is a line char
	function automatic void size_line_byte(input logic [7:0] c);
		bit taken;
		taken = 1'b0;
		if (p_cr) begin
			p_cr = 1'b0;
			if (c == CH_LF) begin
				size_line_end();
				taken = 1'b1;
			end else begin
				size_line_char(CH_CR);
				if (!in_line()) taken = 1'b1;
			end
		end
		if (!taken) begin
			if (c == CH_CR) p_cr = 1'b1;
			else if (c == CH_LF) size_line_end();
			else size_line_char(c);
		end
	endfunction

	function automatic body_out_t dechunk_step(input logic eos, input logic [7:0] c);
		body_out_t r;
		r.pbyte = 8'h00;
		r.pvalid = 1'b0;
		// the mode is only looked at before the body starts
		if (p_phase == PH_START) begin
			if (p_mode == MODE_CHUNKED) begin
				p_phase = PH_SIZE;
				p_size = '0;
				p_digit = 1'b0;
				p_cr = 1'b0;
			end else if (p_mode == MODE_FIXED) begin
				p_left = p_len;
				p_phase = (p_left == 0) ? PH_DONE : PH_FIXED;
			end else if (eos == CMD_EOS) begin
				p_phase = PH_DONE;
			end else begin
				r.pvalid = 1'b1;
				r.pbyte = c;
			end
		end
		if (in_line()) begin
			if (eos == CMD_EOS) p_phase = PH_ERROR;
			else size_line_byte(c);
		end else if (p_phase == PH_DATA || p_phase == PH_FIXED) begin
			if (eos == CMD_EOS) begin
				p_phase = PH_ERROR;
			end else begin
				r.pvalid = 1'b1;
				r.pbyte = c;
				p_left = p_left - 31'd1;
				if (p_left == 0) p_phase = (p_phase == PH_DATA) ? PH_TRAIL : PH_DONE;
			end
		end
		r.stat = (p_phase == PH_DONE) ? ST_DONE : (p_phase == PH_ERROR) ? ST_ERR : ST_RUN;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// driver: bursts of random length with random gaps, plus drain pauses
	// ---------------------------------------------------------------------
	int  burst_left = 1;
	int  gap_left = 0;
	int  burst_cnt = 0;
	bit  draining = 1'b0;

	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
			// transfer still pending, payload held
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (draining && dechunked_q.size() != 0) begin
			// pause until every predicted result has come out
			in_valid <= 1'b0;
		end else if (body_q.size() != 0) begin
			draining = 1'b0;
			in_valid <= 1'b1;
			cmd <= body_q[0].cmd;
			data_byte <= body_q[0].data;
			burst_left--;
			if (burst_left == 0) begin
				burst_cnt++;
				burst_left = $urandom_range(1, 32);
				// about a quarter of the bursts run straight into the next
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				draining = (burst_cnt % 16 == 3);
				if (draining) drains++;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver ready: a style drawn at random, renewed each time ready_cycle runs out
	ready_style_t ready_style = RDY_ALWAYS;
	int           ready_cycle = 0;

	always @(negedge clk) begin
		if (ready_cycle == 0) begin
			ready_style = ready_style_t'($urandom_range(0, 2));
			ready_cycle = 96;
		end
		ready_cycle--;
		case (ready_style)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
			default:    out_ready <= (ready_cycle % 11) >= 4;
		endcase
	end

	// ---------------------------------------------------------------------
	// monitor: predicts on each input transfer, checks each output transfer
	// ---------------------------------------------------------------------
	stream_item_t sent_item;
	body_out_t    want;
	body_out_t    predicted;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			n_results++;
			if (dechunked_q.size() == 0) begin
				errors++;
				$error("result transfer with no prediction waiting: byte %02h valid %0d status %0d",
					payload_byte, payload_valid, status);
			end else begin
				want = dechunked_q.pop_front();
				if (payload_byte !== want.pbyte) begin
					errors++;
					$error("payload_byte: expected %02h, got %02h", want.pbyte, payload_byte);
				end
				if (payload_valid !== want.pvalid) begin
					errors++;
					$error("payload_valid: expected %0d, got %0d", want.pvalid, payload_valid);
				end
				if (status !== want.stat) begin
					errors++;
					$error("status: expected %0d, got %0d", want.stat, status);
				end
				if (want.pvalid) n_delivered++;
				last_status = want.stat;
			end
		end
		in_fire = in_valid && in_ready;
		if (in_fire) begin
			sent_item = body_q.pop_front();
			predicted = dechunk_step(sent_item.cmd, sent_item.data);
			dechunked_q = {dechunked_q, predicted};
			n_items++;
		end
	end

	// watchdog on cycles where nothing moves
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------
	task automatic push_item(input logic c, input logic [7:0] b);
		stream_item_t it;
		it.cmd = c;
		it.data = b;
		body_q = {body_q, it};
		planned++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(CMD_BYTE, b);
	endtask

	task automatic push_eos();
		push_item(CMD_EOS, 8'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			3: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 10) return "0" + 8'(n);
		return (upper ? "A" : "a") + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] any_but_lf();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
		return c;
	endfunction

	// line end is crlf or a bare lf
	task automatic push_eol();
		if ($urandom_range(0, 1)) push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	// size line; plain means no blanks, no padding zeros, no extension
	task automatic push_size_line(input logic [30:0] size, input bit plain);
		int ndig;
		int k;
		ndig = 1;
		while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
		if (!plain) begin
			repeat ($urandom_range(0, 3)) push_byte(pick_blank());
			repeat ($urandom_range(0, 2)) push_byte("0");
		end
		for (k = ndig - 1; k >= 0; k--) begin
			push_byte(hex_char(4'(size >> (4 * k)), 1'($urandom_range(0, 1))));
		end
		if (!plain && $urandom_range(0, 3) == 0) begin
			push_byte(CH_SEMI);
			// extension may hold anything but lf, stray cr included
			repeat ($urandom_range(0, 6)) push_byte(any_but_lf());
		end
		push_eol();
	endtask

	task automatic push_chunk(input logic [30:0] size, input bit plain);
		push_size_line(size, plain);
		repeat (size) push_byte(8'($urandom_range(0, 255)));
		push_eol();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (body_q.size() != 0 || in_valid || dechunked_q.size() != 0);
	endtask

	// register write on the config channel, only while the block is idle
	task automatic write_reg(input logic idx, input logic [30:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == CFG_BODY_MODE) p_mode = val[1:0];
		else p_len = val;
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// closing sequence of a chunked body, normal or broken
	task automatic push_chunked_end(input body_end_t how);
		logic [7:0] c;
		case (how)
			END_ZERO: push_size_line(31'd0, 1'($urandom_range(0, 1)));
			END_NO_DIGIT: begin
				if ($urandom_range(0, 1)) push_byte(CH_SPACE);
				if ($urandom_range(0, 1)) push_byte(CH_SEMI);
				push_eol();
			end
			END_SIGN: begin
				push_byte($urandom_range(0, 1) ? "-" : "+");
				push_byte("1");
				push_eol();
			end
			END_HEX_PREFIX: begin
				push_byte("0");
				push_byte($urandom_range(0, 1) ? "x" : "X");
				push_byte("1");
				push_byte("0");
				push_eol();
			end
			END_BLANK_AFTER: begin
				push_byte("1");
				push_byte("A");
				c = pick_blank();
				push_byte(c);
				// a cr here is stray only if no lf follows
				if (c == CH_CR) push_byte("5");
				push_eol();
			end
			END_BAD_CHAR: begin
				push_byte("1");
				do c = 8'($urandom_range(0, 255));
				while (hex_nibble(c) >= 0 || c == CH_SEMI || c == CH_CR || c == CH_LF);
				push_byte(c);
				push_eol();
			end
			END_OVERFLOW: begin
				// 0x80000000, or nine digits of f
				if ($urandom_range(0, 1)) begin
					push_byte("8");
					repeat (7) push_byte("0");
				end else begin
					repeat (9) push_byte("f");
				end
				push_eol();
			end
			END_TRAILER: begin
				// follows the data of a chunk: the closing line is not empty
				c = any_but_lf();
				push_byte(c);
				if (c == CH_CR) push_byte(8'h41);
				push_eol();
			end
			END_EOS_DATA: begin
				// largest legal size, cut short by end of stream
				push_size_line(31'h7FFF_FFFF, 1'b1);
				repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
				push_eos();
			end
			default: begin
				if ($urandom_range(0, 1)) push_byte("1");
				push_eos();
			end
		endcase
	endtask

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	int         pick;
	int         n_body;
	logic [30:0] sz;
	logic [30:0] len;
	body_end_t  how;
	string      body_kind;
	string      end_kind;

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// mode three behaves as close: every byte passes, length unused
		write_reg(CFG_BODY_MODE, 31'(MODE_CLOSE_ALT));
		write_reg(CFG_CONTENT_LENGTH, 31'h7FFF_FFFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_SEMI);
		wait_drained();

		// close mode proper, still sitting in the start phase
		write_reg(CFG_BODY_MODE, 31'(MODE_CLOSE));
		write_reg(CFG_CONTENT_LENGTH, 31'd0);
		repeat (60) push_byte(8'($urandom_range(0, 255)));
		wait_drained();

		// one body per reset: choose how the main part is framed
		pick = $urandom_range(0, 9);
		end_kind = "stream end";
		if (pick < 7) begin
			body_kind = "chunked";
			write_reg(CFG_CONTENT_LENGTH, 31'($urandom_range(1, 100)));
			write_reg(CFG_BODY_MODE, 31'(MODE_CHUNKED));
			// every blank kind up front, extension with a stray cr
			push_byte(CH_SPACE);
			push_byte(CH_TAB);
			push_byte(CH_VT);
			push_byte(CH_FF);
			push_byte(CH_CR);
			push_byte("4");
			push_byte(CH_SEMI);
			push_byte("a");
			push_byte(CH_CR);
			push_byte("b");
			push_byte(CH_CR);
			push_byte(CH_LF);
			push_byte(8'h00);
			push_byte(8'hFF);
			push_byte(CH_CR);
			push_byte(CH_LF);
			push_byte(CH_LF);
			// well-formed chunks with random content, mostly short
			while (planned < 1200) begin
				sz = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(49, 300)) :
					31'($urandom_range(1, 48));
				push_chunk(sz, $urandom_range(0, 2) == 0);
			end
			how = ($urandom_range(0, 2) == 0) ? END_ZERO :
				body_end_t'($urandom_range(int'(END_ZERO), int'(END_EOS_LINE)));
			if (how == END_TRAILER) begin
				// a full chunk whose closing line is not empty
				push_size_line(31'd3, 1'b1);
				repeat (3) push_byte(8'($urandom_range(0, 255)));
			end
			push_chunked_end(how == END_TRAILER ? END_TRAILER : how);
			end_kind = how.name();
		end else if (pick < 9) begin
			body_kind = "fixed length";
			case ($urandom_range(0, 3))
				0: len = 31'd0;
				3: len = 31'h7FFF_FFFF;
				default: len = 31'($urandom_range(1, 1200));
			endcase
			write_reg(CFG_CONTENT_LENGTH, len);
			write_reg(CFG_BODY_MODE, 31'(MODE_FIXED));
			if (len == 0) begin
				end_kind = "zero length";
			end else if (len > 1200) begin
				repeat (1200) push_byte(8'($urandom_range(0, 255)));
				push_eos();
				end_kind = "early end";
			end else if ($urandom_range(0, 1)) begin
				repeat (len) push_byte(8'($urandom_range(0, 255)));
				end_kind = "full length";
			end else begin
				n_body = $urandom_range(0, int'(len) - 1);
				repeat (n_body) push_byte(8'($urandom_range(0, 255)));
				push_eos();
				end_kind = "early end";
			end
		end else begin
			body_kind = "until close";
			repeat (1200) push_byte(8'($urandom_range(0, 255)));
			push_eos();
		end

		// the block is finished now and must ignore whatever follows
		repeat (16) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		// short bodies are topped up with ignored items to keep the run length
		while (planned < 1280) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		wait_drained();
		write_reg(CFG_BODY_MODE, 31'(MODE_FIXED));
		write_reg(CFG_CONTENT_LENGTH, 31'd5);
		repeat (8) push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (dechunked_q.size() != 0) begin
			errors++;
			$error("%0d predicted results never came out", dechunked_q.size());
		end

		$display("coverage: %0d stream items, %0d results, %0d body bytes, %0d register writes",
			n_items, n_results, n_delivered, n_writes);
		$display("coverage: %s body ending by %s, final status %0d, %0d drain pauses",
			body_kind, end_kind, last_status, drains);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
